// File: rtl/adc_piecewise_linear_calibration_top_defines.svh
// assertion macros for the piecewise linear calibration block
`ifndef ADC_PIECEWISE_LINEAR_CALIBRATION_TOP_DEFINES_SVH
`define ADC_PIECEWISE_LINEAR_CALIBRATION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PLC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plc assertion failed");
`define PLC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plc assertion failed");
`else
`define PLC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PLC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/plc_pkg.sv
// shared types and constants of the piecewise linear calibration block
`timescale 1ns / 1ps

package plc_pkg;

  localparam int RAW_W      = 16;
  localparam int MV_W       = 12;
  localparam int VAL_W      = 15;
  localparam int SEG_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam int MAX_POINTS = 4;
  localparam int DIV16_SH   = 4;
  localparam int DX_W       = 12;
  localparam int DMAG_W     = 15;
  localparam int PROD_W     = 27;
  localparam int Q_W        = 15;
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = 5;

  typedef logic signed [MV_W-1:0]  mv_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [SEG_W-1:0]        seg_t;
  typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [PROD_W:0]         trial_t;
  typedef logic [PROD_W-1:0]       prod_t;

  localparam cfg_idx_t REG_IN_BASE  = 3'd0;
  localparam cfg_idx_t REG_OUT_BASE = 3'd4;

  localparam mv_t IN_RESET [MAX_POINTS] = '{12'sd7, 12'sd660, 12'sd1260, 12'sd2047};
  localparam val_t OUT_RESET [MAX_POINTS] = '{15'sd160, 15'sd280, 15'sd390, 15'sd510};

  typedef struct packed {
    mv_t  x;
    seg_t seg;
    logic lo;
    logic hi;
    logic interp;
    logic neg;
    val_t base;
  } side_t;

endpackage

// File: rtl/adc_piecewise_linear_calibration_top.sv
// throughput: one word per cycle; busy stays low, the pipeline never stalls
// the depth is set by four front stages, five divider stages of three quotient bits
// and the output register
// synchronous reset clears all valid bits and reloads the calibration table defaults
`timescale 1ns / 1ps
`include "adc_piecewise_linear_calibration_top_defines.svh"

module adc_piecewise_linear_calibration_top #(
  parameter int TABLE_POINTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [plc_pkg::RAW_W-1:0]  in_raw_sample,
  input  logic                              cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output logic                              out_strobe,
  output logic signed [plc_pkg::MV_W-1:0]   out_millivolts,
  output logic signed [plc_pkg::VAL_W-1:0]  out_value_tenths,
  output logic [plc_pkg::SEG_W-1:0]         out_segment,
  output logic                              out_clamped_low,
  output logic                              out_clamped_high
);

  plc_pkg::mv_t             in_pts  [TABLE_POINTS];
  plc_pkg::val_t            out_pts [TABLE_POINTS];
  logic                     prep_vld;
  plc_pkg::prod_t           prep_mag;
  logic [plc_pkg::DX_W-1:0] prep_div;
  plc_pkg::side_t           prep_side;
  logic                     div_vld;
  logic [plc_pkg::Q_W-1:0]  div_q;
  plc_pkg::side_t           div_side;

  assign busy = 1'b0;

  plc_regs #(.TABLE_POINTS(TABLE_POINTS)) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_pts    (in_pts),
    .out_pts   (out_pts)
  );

  plc_prep #(.TABLE_POINTS(TABLE_POINTS)) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_raw   (in_raw_sample),
    .in_pts   (in_pts),
    .out_pts  (out_pts),
    .out_vld  (prep_vld),
    .out_mag  (prep_mag),
    .out_div  (prep_div),
    .out_side (prep_side)
  );

  plc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (prep_vld),
    .in_mag   (prep_mag),
    .in_div   (prep_div),
    .in_side  (prep_side),
    .out_vld  (div_vld),
    .out_q    (div_q),
    .out_side (div_side)
  );

  // signed quotient added to the segment base when interpolating, else the base alone
  logic signed [plc_pkg::VAL_W:0] q_s_c;
  logic signed [plc_pkg::VAL_W:0] sum_c;
  plc_pkg::val_t                  val_c;

  always_comb begin
    q_s_c = div_side.neg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    sum_c = {div_side.base[plc_pkg::VAL_W-1], div_side.base} + q_s_c;
    val_c = div_side.interp ? sum_c[plc_pkg::VAL_W-1:0] : div_side.base;
  end

  logic          out_strobe_r;
  plc_pkg::mv_t  out_mv_r;
  plc_pkg::val_t out_val_r;
  plc_pkg::seg_t out_seg_r;
  logic          out_lo_r;
  logic          out_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_mv_r  <= div_side.x;
    out_val_r <= val_c;
    out_seg_r <= div_side.seg;
    out_lo_r  <= div_side.lo;
    out_hi_r  <= div_side.hi;
  end

  assign out_strobe       = out_strobe_r;
  assign out_millivolts   = out_mv_r;
  assign out_value_tenths = out_val_r;
  assign out_segment      = out_seg_r;
  assign out_clamped_low  = out_lo_r;
  assign out_clamped_high = out_hi_r;

  `PLC_ASSERT_IMP(a_clamp_excl, clk, rst_n, out_strobe, !(out_clamped_low && out_clamped_high))
  `PLC_ASSERT_IMP(a_seg_range, clk, rst_n, out_strobe, out_segment <= plc_pkg::seg_t'(TABLE_POINTS - 2))
  `PLC_ASSERT_IMP(a_low_clamp, clk, rst_n, out_strobe && out_clamped_low, out_value_tenths == out_pts[0] && out_segment == '0)
  `PLC_ASSERT_NXT(a_strobe_follows, clk, rst_n, div_vld, out_strobe)

endmodule

// File: rtl/plc_regs.sv
// calibration table registers written through the configuration port
`timescale 1ns / 1ps

module plc_regs #(
  parameter int TABLE_POINTS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  plc_pkg::cfg_idx_t               cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output plc_pkg::mv_t                    in_pts [TABLE_POINTS],
  output plc_pkg::val_t                   out_pts [TABLE_POINTS]
);

  plc_pkg::mv_t  in_pts_r  [TABLE_POINTS];
  plc_pkg::val_t out_pts_r [TABLE_POINTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < TABLE_POINTS; j++) begin
        in_pts_r[j]  <= plc_pkg::IN_RESET[j];
        out_pts_r[j] <= plc_pkg::OUT_RESET[j];
      end
    end else if (cfg_we) begin
      for (int j = 0; j < TABLE_POINTS; j++) begin
        if (cfg_index == plc_pkg::REG_IN_BASE + plc_pkg::cfg_idx_t'(j)) begin
          in_pts_r[j] <= cfg_wdata[plc_pkg::MV_W-1:0];
        end
        if (cfg_index == plc_pkg::REG_OUT_BASE + plc_pkg::cfg_idx_t'(j)) begin
          out_pts_r[j] <= cfg_wdata;
        end
      end
    end
  end

  assign in_pts  = in_pts_r;
  assign out_pts = out_pts_r;

endmodule

// File: rtl/plc_prep.sv
// front pipeline: scale to millivolts, segment search, point select, multiply
`timescale 1ns / 1ps

module plc_prep #(
  parameter int TABLE_POINTS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  logic signed [plc_pkg::RAW_W-1:0]   in_raw,
  input  plc_pkg::mv_t                       in_pts [TABLE_POINTS],
  input  plc_pkg::val_t                      out_pts [TABLE_POINTS],
  output logic                               out_vld,
  output plc_pkg::prod_t                     out_mag,
  output logic [plc_pkg::DX_W-1:0]           out_div,
  output plc_pkg::side_t                     out_side
);

  // stage 1: divide by 16 toward zero
  logic         rnd_c;
  plc_pkg::mv_t x_c;
  logic         s1_vld_r;
  plc_pkg::mv_t s1_x_r;

  assign rnd_c = in_raw[plc_pkg::RAW_W-1] & (|in_raw[plc_pkg::DIV16_SH-1:0]);
  assign x_c   = in_raw[plc_pkg::RAW_W-1:plc_pkg::DIV16_SH] + plc_pkg::mv_t'(rnd_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r <= x_c;
  end

  // stage 2: clamps and segment search
  logic          lo_c;
  logic          hi_c;
  plc_pkg::seg_t seg_c;
  logic          s2_vld_r;
  plc_pkg::mv_t  s2_x_r;
  plc_pkg::seg_t s2_seg_r;
  logic          s2_lo_r;
  logic          s2_hi_r;

  always_comb begin
    lo_c  = (s1_x_r <= in_pts[0]);
    hi_c  = !lo_c && (s1_x_r >= in_pts[TABLE_POINTS-1]);
    seg_c = plc_pkg::seg_t'(TABLE_POINTS - 2);
    for (int j = TABLE_POINTS - 3; j >= 0; j--) begin
      if (s1_x_r < in_pts[j+1]) begin
        seg_c = plc_pkg::seg_t'(j);
      end
    end
    if (lo_c) begin
      seg_c = '0;
    end
    if (hi_c) begin
      seg_c = plc_pkg::seg_t'(TABLE_POINTS - 2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_x_r   <= s1_x_r;
    s2_seg_r <= seg_c;
    s2_lo_r  <= lo_c;
    s2_hi_r  <= hi_c;
  end

  // stage 3: point select and differences
  plc_pkg::mv_t                    pin_lo;
  plc_pkg::mv_t                    pin_hi;
  plc_pkg::val_t                   pout_lo;
  plc_pkg::val_t                   pout_hi;
  logic signed [plc_pkg::MV_W:0]   dx_c;
  logic signed [plc_pkg::MV_W:0]   width_c;
  logic signed [plc_pkg::VAL_W:0]  dout_c;
  logic signed [plc_pkg::VAL_W:0]  dout_abs_c;
  plc_pkg::side_t                  side_c;
  logic                            s3_vld_r;
  plc_pkg::side_t                  s3_side_r;
  logic [plc_pkg::DMAG_W-1:0]      s3_dmag_r;
  logic [plc_pkg::DX_W-1:0]        s3_dx_r;
  logic [plc_pkg::DX_W-1:0]        s3_div_r;

  always_comb begin
    pin_lo  = in_pts[0];
    pin_hi  = in_pts[1];
    pout_lo = out_pts[0];
    pout_hi = out_pts[1];
    for (int j = 0; j < TABLE_POINTS - 1; j++) begin
      if (s2_seg_r == plc_pkg::seg_t'(j)) begin
        pin_lo  = in_pts[j];
        pin_hi  = in_pts[j+1];
        pout_lo = out_pts[j];
        pout_hi = out_pts[j+1];
      end
    end
    dx_c       = {s2_x_r[plc_pkg::MV_W-1], s2_x_r} - {pin_lo[plc_pkg::MV_W-1], pin_lo};
    width_c    = {pin_hi[plc_pkg::MV_W-1], pin_hi} - {pin_lo[plc_pkg::MV_W-1], pin_lo};
    dout_c     = {pout_hi[plc_pkg::VAL_W-1], pout_hi} - {pout_lo[plc_pkg::VAL_W-1], pout_lo};
    dout_abs_c = dout_c[plc_pkg::VAL_W] ? -dout_c : dout_c;

    side_c.x      = s2_x_r;
    side_c.seg    = s2_seg_r;
    side_c.lo     = s2_lo_r;
    side_c.hi     = s2_hi_r;
    side_c.interp = !s2_lo_r && !s2_hi_r && (width_c > 0);
    side_c.neg    = dout_c[plc_pkg::VAL_W];
    priority if (s2_lo_r) begin
      side_c.base = out_pts[0];
    end else if (s2_hi_r) begin
      side_c.base = out_pts[TABLE_POINTS-1];
    end else begin
      side_c.base = pout_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_side_r <= side_c;
    s3_dmag_r <= dout_abs_c[plc_pkg::DMAG_W-1:0];
    s3_dx_r   <= dx_c[plc_pkg::DX_W-1:0];
    s3_div_r  <= side_c.interp ? width_c[plc_pkg::DX_W-1:0] : plc_pkg::DX_W'(1);
  end

  // stage 4: product magnitude
  logic           s4_vld_r;
  plc_pkg::prod_t s4_mag_r;
  logic [plc_pkg::DX_W-1:0] s4_div_r;
  plc_pkg::side_t s4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_mag_r  <= plc_pkg::prod_t'(s3_dmag_r) * plc_pkg::prod_t'(s3_dx_r);
    s4_div_r  <= s3_div_r;
    s4_side_r <= s3_side_r;
  end

  assign out_vld  = s4_vld_r;
  assign out_mag  = s4_mag_r;
  assign out_div  = s4_div_r;
  assign out_side = s4_side_r;

endmodule

// File: rtl/plc_div.sv
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps

module plc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  plc_pkg::prod_t            in_mag,
  input  logic [plc_pkg::DX_W-1:0]  in_div,
  input  plc_pkg::side_t            in_side,
  output logic                      out_vld,
  output logic [plc_pkg::Q_W-1:0]   out_q,
  output plc_pkg::side_t            out_side
);

  localparam int NS = plc_pkg::DIV_STAGES;

  logic                     vld_r  [NS];
  plc_pkg::prod_t           rem_r  [NS];
  logic [plc_pkg::DX_W-1:0] div_r  [NS];
  logic [plc_pkg::Q_W-1:0]  q_r    [NS];
  plc_pkg::side_t           side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic                     vld_in;
    plc_pkg::prod_t           rem_in;
    logic [plc_pkg::DX_W-1:0] div_in;
    logic [plc_pkg::Q_W-1:0]  q_in;
    plc_pkg::side_t           side_in;
    plc_pkg::prod_t           rem_c;
    logic [plc_pkg::Q_W-1:0]  q_c;
    plc_pkg::trial_t          trial;

    if (s == 0) begin : g_first
      assign vld_in  = in_vld;
      assign rem_in  = in_mag;
      assign div_in  = in_div;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign div_in  = div_r[s-1];
      assign q_in    = q_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      rem_c = rem_in;
      q_c   = q_in;
      trial = '0;
      for (int b = 0; b < plc_pkg::DIV_BITS; b++) begin
        trial = plc_pkg::trial_t'(rem_c)
              - (plc_pkg::trial_t'(div_in) << (plc_pkg::Q_W - 1 - plc_pkg::DIV_BITS * s - b));
        if (!trial[plc_pkg::PROD_W]) begin
          rem_c = trial[plc_pkg::PROD_W-1:0];
          q_c[plc_pkg::Q_W - 1 - plc_pkg::DIV_BITS * s - b] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_c;
      div_r[s]  <= div_in;
      q_r[s]    <= q_c;
      side_r[s] <= side_in;
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_q    = q_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

// File: sim/plc_calibration_checker.sv
// checker that predicts and compares the calibrated words of the piecewise linear block
`timescale 1ns / 1ps

module plc_calibration_checker #(
  parameter int TABLE_POINTS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [plc_pkg::RAW_W-1:0]  in_raw_sample,
  input  logic                              cfg_we,
  input  logic [plc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [plc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              out_strobe,
  input  logic signed [plc_pkg::MV_W-1:0]   out_millivolts,
  input  logic signed [plc_pkg::VAL_W-1:0]  out_value_tenths,
  input  logic [plc_pkg::SEG_W-1:0]         out_segment,
  input  logic                              out_clamped_low,
  input  logic                              out_clamped_high,
  output int                                fail_count,
  output int                                pending,
  output int                                low_clamps,
  output int                                high_clamps,
  output int                                interpolated
);
  import plc_pkg::*;

  typedef struct packed {
    mv_t  mv;
    val_t tenths;
    seg_t seg;
    logic lo;
    logic hi;
  } reading_t;

  reading_t expected_q[$];
  mv_t      brk [MAX_POINTS];
  val_t     lvl [MAX_POINTS];

  function automatic reading_t calibrate(logic signed [RAW_W-1:0] raw);
    reading_t r;
    int x, val, span, i, last;
    last = TABLE_POINTS - 1;
    x = int'(raw) / (1 << DIV16_SH);
    r = '0;
    r.mv = mv_t'(x);
    if (x <= int'(brk[0])) begin
      val = int'(lvl[0]);
      r.lo = 1'b1;
    end else if (x >= int'(brk[last])) begin
      val = int'(lvl[last]);
      r.seg = seg_t'(last - 1);
      r.hi = 1'b1;
    end else begin
      i = 0;
      while (i + 1 < last && x >= int'(brk[i+1])) i++;
      r.seg = seg_t'(i);
      span = int'(brk[i+1]) - int'(brk[i]);
      if (span <= 0) begin
        val = int'(lvl[i]);
      end else begin
        val = int'(lvl[i]) + ((int'(lvl[i+1]) - int'(lvl[i])) * (x - int'(brk[i]))) / span;
      end
    end
    r.tenths = val_t'(val);
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 40) begin
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        brk[k] = IN_RESET[k];
        lvl[k] = OUT_RESET[k];
      end
      expected_q.delete();
      fail_count = 0;
      low_clamps = 0;
      high_clamps = 0;
      interpolated = 0;
    end else begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          report("unexpected word, value", int'(out_value_tenths), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_millivolts !== want.mv)
            report("millivolts", int'(out_millivolts), int'(want.mv));
          if (out_value_tenths !== want.tenths)
            report("value_tenths", int'(out_value_tenths), int'(want.tenths));
          if (out_segment !== want.seg)
            report("segment", int'(out_segment), int'(want.seg));
          if (out_clamped_low !== want.lo)
            report("clamped_low", int'(out_clamped_low), int'(want.lo));
          if (out_clamped_high !== want.hi)
            report("clamped_high", int'(out_clamped_high), int'(want.hi));
          if (want.lo) low_clamps++;
          else if (want.hi) high_clamps++;
          else interpolated++;
        end
      end
      if (cfg_we) begin
        if (cfg_index < REG_OUT_BASE) begin
          brk[cfg_index - REG_IN_BASE] = mv_t'(cfg_wdata[MV_W-1:0]);
        end else begin
          lvl[cfg_index - REG_OUT_BASE] = val_t'(cfg_wdata);
        end
      end
      if (start && !busy) expected_q.push_back(calibrate(in_raw_sample));
    end
    pending = expected_q.size();
  end

endmodule

// File: sim/testbench.sv
// top of the calibration block testbench: stimulus, table settings and verdict
`timescale 1ns / 1ps

module testbench;
  import plc_pkg::*;

  localparam int NPOINTS       = 4;
  localparam int LATENCY       = 9;
  localparam int SETTLE        = LATENCY + 4;
  localparam int STALL_LIMIT   = 1000;
  localparam int PHASE_SAMPLES = 50;
  localparam int NUM_KINDS     = 6;
  localparam int NUM_PHASES    = 7;

  typedef enum int {
    TBL_ORDERED,
    TBL_EXTREME,
    TBL_UNORDERED,
    TBL_DUPLICATE,
    TBL_NARROW,
    TBL_EXTREME_INV
  } table_kind_e;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [RAW_W-1:0]   in_raw_sample = '0;
  logic                      cfg_we = 1'b0;
  cfg_idx_t                  cfg_index = REG_IN_BASE;
  logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                      out_strobe;
  logic signed [MV_W-1:0]    out_millivolts;
  logic signed [VAL_W-1:0]   out_value_tenths;
  logic [SEG_W-1:0]          out_segment;
  logic                      out_clamped_low;
  logic                      out_clamped_high;

  int fail_count, pending, low_clamps, high_clamps, interpolated;
  int brk [NPOINTS];
  int lvl [NPOINTS];
  int samples_sent = 0;
  int table_settings = 1;
  int idle_cycles = 0;
  bit steady = 1'b0;

  int directed_raw [23] = '{-32768, 32767, 0, -1, -16, -17, 15, 16, 112, 127, 128, 129,
                            10559, 10560, 10561, 20159, 20160, 20176, 32751, 32752,
                            1000, 5000, 25000};

  adc_piecewise_linear_calibration_top #(.TABLE_POINTS(NPOINTS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_raw_sample    (in_raw_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_millivolts   (out_millivolts),
    .out_value_tenths (out_value_tenths),
    .out_segment      (out_segment),
    .out_clamped_low  (out_clamped_low),
    .out_clamped_high (out_clamped_high)
  );

  plc_calibration_checker #(.TABLE_POINTS(NPOINTS)) calib_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_raw_sample    (in_raw_sample),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_millivolts   (out_millivolts),
    .out_value_tenths (out_value_tenths),
    .out_segment      (out_segment),
    .out_clamped_low  (out_clamped_low),
    .out_clamped_high (out_clamped_high),
    .fail_count       (fail_count),
    .pending          (pending),
    .low_clamps       (low_clamps),
    .high_clamps      (high_clamps),
    .interpolated     (interpolated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int raw_for_mv(input int mv);
    int x, off;
    x = (mv < -2048) ? -2048 : (mv > 2047) ? 2047 : mv;
    off = $urandom_range(0, 15);
    if (x == 0) return int'($urandom_range(0, 30)) - 15;
    if (x == -2048) return x * 16;
    if (x < 0) return x * 16 - off;
    return x * 16 + off;
  endfunction

  task automatic send_sample(input int raw);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      in_raw_sample <= RAW_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_raw_sample <= raw[RAW_W-1:0];
    do @(posedge clk); while (busy);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic random_burst(input int count);
    int n, r, x, lo_bp, hi_bp;
    lo_bp = brk[0];
    hi_bp = brk[0];
    for (n = 1; n < NPOINTS; n++) begin
      if (brk[n] < lo_bp) lo_bp = brk[n];
      if (brk[n] > hi_bp) hi_bp = brk[n];
    end
    for (n = 0; n < count; n++) begin
      if (n % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 2) begin
        send_sample($urandom);
      end else begin
        if (r < 4) begin
          x = brk[$urandom_range(0, NPOINTS - 1)] + int'($urandom_range(0, 2)) - 1;
        end else begin
          x = int'($urandom_range(0, hi_bp - lo_bp + 6)) + lo_bp - 3;
        end
        send_sample(raw_for_mv(x));
      end
    end
  endtask

  task automatic build_table(input table_kind_e kind);
    int a, b, t, base;
    bit descending, shuffled;
    descending = (kind == TBL_UNORDERED) && ($urandom_range(0, 1) == 1);
    shuffled = (kind == TBL_UNORDERED) && !descending;
    for (a = 0; a < NPOINTS; a++) begin
      brk[a] = int'($urandom_range(0, 4095)) - 2048;
      lvl[a] = int'($urandom_range(0, 20000)) - 10000;
    end
    if (!shuffled) begin
      for (a = 0; a < NPOINTS - 1; a++) begin
        for (b = a + 1; b < NPOINTS; b++) begin
          if (descending ? brk[a] < brk[b] : brk[a] > brk[b]) begin
            t = brk[a];
            brk[a] = brk[b];
            brk[b] = t;
          end
        end
      end
    end
    case (kind)
      TBL_DUPLICATE: begin
        brk[2] = brk[1];
        if ($urandom_range(0, 1) == 1) brk[0] = brk[1];
      end
      TBL_EXTREME: begin
        brk = '{-2048, -683, 682, 2047};
        lvl = '{-10000, 10000, -10000, 10000};
      end
      TBL_EXTREME_INV: begin
        brk = '{-2048, -2047, 2046, 2047};
        lvl = '{10000, -10000, 10000, -10000};
      end
      TBL_NARROW: begin
        base = int'($urandom_range(0, 4092)) - 2048;
        for (a = 0; a < NPOINTS; a++) begin
          brk[a] = base + a;
          lvl[a] = ($urandom_range(0, 1) == 1) ? 10000 : -10000;
        end
      end
      default: ;
    endcase
  endtask

  task automatic load_table();
    int k;
    logic [CFG_DATA_W-1:0] word;
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    for (k = 0; k < NPOINTS; k++) begin
      word = CFG_DATA_W'($urandom);
      word[MV_W-1:0] = brk[k][MV_W-1:0];
      cfg_we <= 1'b1;
      cfg_index <= cfg_idx_t'(REG_IN_BASE + k);
      cfg_wdata <= word;
      @(negedge clk);
      cfg_index <= cfg_idx_t'(REG_OUT_BASE + k);
      cfg_wdata <= lvl[k][CFG_DATA_W-1:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    table_settings++;
  endtask

  initial begin
    int k;
    for (k = 0; k < NPOINTS; k++) begin
      brk[k] = int'(IN_RESET[k]);
      lvl[k] = int'(OUT_RESET[k]);
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_raw[k]) send_sample(directed_raw[k]);
    random_burst(PHASE_SAMPLES);

    for (k = 0; k < NUM_PHASES; k++) begin
      build_table(table_kind_e'(k % NUM_KINDS));
      load_table();
      random_burst(PHASE_SAMPLES);
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("sent %0d converter samples across %0d calibration tables",
             samples_sent, table_settings);
    $display("checked words: %0d low clamp, %0d high clamp, %0d interpolated",
             low_clamps, high_clamps, interpolated);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/plc_pkg.sv
rtl/plc_regs.sv
rtl/plc_prep.sv
rtl/plc_div.sv
rtl/adc_piecewise_linear_calibration_top.sv
sim/plc_calibration_checker.sv
sim/testbench.sv
